FILE: design/led_quad_frame_buffer_assert.svh
// Assertion macros shared by the LED quad frame buffer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LED_QUAD_FRAME_BUFFER_ASSERT_SVH
`define LED_QUAD_FRAME_BUFFER_ASSERT_SVH
`ifndef SYNTH
// Check on a clock, switched off while reset is held low.
`define LQFB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Check on a clock that also holds during reset.
`define LQFB_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LQFB_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define LQFB_ASSERT(lbl, clk, prop, msg)
`endif
`endif

FILE: design/lqfb_pkg.sv
// Package for the LED quad frame buffer: sizes, codes, controller/datapath structs,
// offset tables and the level saturation function. No dependencies.
`default_nettype none

package lqfb_pkg;

    localparam int LEDS_PER_QUAD = 64;
    localparam int MAX_QUADS     = 4;
    localparam int LEVEL_W       = 4;
    localparam int QUAD_W        = 2;
    localparam int LED_W         = 6;
    localparam int ROW_W         = LEDS_PER_QUAD * LEVEL_W;
    localparam int WORD_W        = 64;

    localparam logic [3:0] LEVEL_MAX = 4'd15;
    localparam logic [2:0] ACTIVE_MAX = 3'd4;
    localparam logic [2:0] ACTIVE_PAIR = 3'd2;

    // Quad offsets on the grid, indexed by quad number
    localparam logic [3:0] BASE_XOFF [MAX_QUADS] = '{4'd0, 4'd8, 4'd0, 4'd8};
    localparam logic [3:0] BASE_YOFF [MAX_QUADS] = '{4'd0, 4'd0, 4'd8, 4'd8};

    typedef enum logic [1:0] {
        CMD_SET_ONE = 2'd0,
        CMD_SET_ALL = 2'd1,
        CMD_REFRESH = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        REG_RING_MODE    = 2'd0,
        REG_ACTIVE_QUADS = 2'd1,
        REG_ROTATION     = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET_ONE,
        ST_SET_ALL,
        ST_REFRESH
    } state_t;

    typedef enum logic [1:0] {
        DP_NONE,
        DP_WRITE_ONE,
        DP_WRITE_ALL,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic              capture;
        dp_op_t            op;
        logic [QUAD_W-1:0] quad;
        logic              last;
    } dp_cmd_t;

    typedef struct packed {
        logic [MAX_QUADS-1:0] dirty;
        logic [2:0]           active_count;
        logic                 out_free;
    } dp_status_t;

    // New level: absolute or relative, clamped to 0..15
    function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] old,
                                                     input logic signed [7:0] delta,
                                                     input logic rel);
        logic signed [8:0] sum;
        sum = rel ? ($signed({5'b0, old}) + $signed({delta[7], delta}))
                  : $signed({delta[7], delta});
        if (sum < 9'sd0) begin
            return '0;
        end else if (sum > 9'sd15) begin
            return LEVEL_MAX;
        end
        return sum[LEVEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/led_quad_frame_buffer.sv
// Top level of the LED quad frame buffer: controller plus datapath.
// Depends on lqfb_pkg, lqfb_ctrl and lqfb_datapath.
//
// Usage: requests enter on the s_ channel (valid/ready) and carry a command:
// set one LED, set all LEDs of the active quads, or refresh. Set commands give
// no result; a refresh gives one result per dirty active quad on the m_ channel
// (valid/ready), in ascending quad order, with m_last_quad on the final one.
// Configuration (ring mode, active quad count, rotation) is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// Timing: one request is worked at a time. A single set writes its LED in the
// ST_SET_ONE state and then returns to idle and ready. Set-all and refresh each
// scan the active quads, one quad per cycle while a refresh is not held on a
// dirty quad by a busy output register; a quad is emitted into the output register
// in its scan cycle and shows on m_valid the cycle after. The whole 256-bit quad
// row is read at once, which sets the rate. Stalls: when the receiver holds
// m_ready low, the scan waits on the next dirty quad; the final result may sit
// in the output register while the next request is accepted.
// Reset: aresetn low clears all levels to zero, all dirty marks, the output
// valid and restores ring_mode 0, active_quads 4, rotation 0; no clearing pass.
`default_nettype none

module led_quad_frame_buffer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [2:0]        cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_command,
    input  wire logic              s_relative,
    input  wire logic [5:0]        s_col_or_led,
    input  wire logic [3:0]        s_row_or_ring,
    input  wire logic signed [7:0] s_value,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_quad_index,
    output logic [3:0]             m_x_offset,
    output logic [3:0]             m_y_offset,
    output logic [63:0]            m_levels_a,
    output logic [63:0]            m_levels_b,
    output logic [63:0]            m_levels_c,
    output logic [63:0]            m_levels_d,
    output logic                   m_last_quad
);
    import lqfb_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    lqfb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    lqfb_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_relative    (s_relative),
        .s_col_or_led  (s_col_or_led),
        .s_row_or_ring (s_row_or_ring),
        .s_value       (s_value),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_quad_index  (m_quad_index),
        .m_x_offset    (m_x_offset),
        .m_y_offset    (m_y_offset),
        .m_levels_a    (m_levels_a),
        .m_levels_b    (m_levels_b),
        .m_levels_c    (m_levels_c),
        .m_levels_d    (m_levels_d),
        .m_last_quad   (m_last_quad)
    );

endmodule

`default_nettype wire

FILE: design/lqfb_ctrl.sv
// Controller of the LED quad frame buffer: request sequencing and quad scanning.
// Depends on lqfb_pkg and led_quad_frame_buffer_assert.svh.
`default_nettype none

module lqfb_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_command,
    input  wire lqfb_pkg::dp_status_t status,
    output lqfb_pkg::dp_cmd_t        cmd
);
    import lqfb_pkg::*;

    `include "led_quad_frame_buffer_assert.svh"

    state_t            state_reg, state_next;
    logic [QUAD_W-1:0] quad_reg, quad_next;

    logic quad_active;
    logic last_step;
    logic emit_wanted;
    logic later_dirty;

    // Scan position relative to the active quad count
    assign quad_active = ({1'b0, quad_reg} < status.active_count);
    assign last_step   = (({1'b0, quad_reg} + 3'd1) >= status.active_count);
    assign emit_wanted = quad_active && status.dirty[quad_reg];

    // Any dirty active quad still ahead in this refresh
    always_comb begin
        later_dirty = 1'b0;
        for (int j = 0; j < MAX_QUADS; j++) begin
            if ((3'(j) > {1'b0, quad_reg}) && (3'(j) < status.active_count)
                    && status.dirty[j]) begin
                later_dirty = 1'b1;
            end
        end
    end

    // Next state and scan counter
    always_comb begin
        state_next = state_reg;
        quad_next  = quad_reg;
        case (state_reg)
            ST_IDLE: begin
                quad_next = '0;
                if (s_valid) begin
                    case (cmd_code_t'(s_command))
                        CMD_SET_ONE: state_next = ST_SET_ONE;
                        CMD_SET_ALL: state_next = ST_SET_ALL;
                        CMD_REFRESH: state_next = ST_REFRESH;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SET_ONE: begin
                state_next = ST_IDLE;
            end
            ST_SET_ALL: begin
                if (last_step) begin
                    state_next = ST_IDLE;
                end else begin
                    quad_next = quad_reg + 1'b1;
                end
            end
            ST_REFRESH: begin
                // hold on a dirty quad until the output slot frees up
                if (!(emit_wanted && !status.out_free)) begin
                    if (last_step) begin
                        state_next = ST_IDLE;
                    end else begin
                        quad_next = quad_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs to the datapath and the input channel
    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.op      = DP_NONE;
        cmd.quad    = quad_reg;
        cmd.last    = !later_dirty;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_SET_ONE: begin
                cmd.op = DP_WRITE_ONE;
            end
            ST_SET_ALL: begin
                if (quad_active) begin
                    cmd.op = DP_WRITE_ALL;
                end
            end
            ST_REFRESH: begin
                if (emit_wanted && status.out_free) begin
                    cmd.op = DP_EMIT;
                end
            end
            default: begin
                cmd.op = DP_NONE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            quad_reg  <= '0;
        end else begin
            state_reg <= state_next;
            quad_reg  <= quad_next;
        end
    end

    `LQFB_ASSERT_RST(a_emit_slot_free, aclk, aresetn, (cmd.op == DP_EMIT) |-> status.out_free, "emit while output slot busy")
    `LQFB_ASSERT_RST(a_emit_dirty_active, aclk, aresetn, (cmd.op == DP_EMIT) |-> (status.dirty[cmd.quad] && ({1'b0, cmd.quad} < status.active_count)), "emit of clean or inactive quad")
    `LQFB_ASSERT_RST(a_set_one_single, aclk, aresetn, (state_reg == ST_SET_ONE) |=> (state_reg == ST_IDLE), "single write took more than one cycle")

endmodule

`default_nettype wire

FILE: design/lqfb_datapath.sv
// Datapath of the LED quad frame buffer: config registers, level store, dirty marks
// and the result register. Depends on lqfb_pkg.
`default_nettype none

module lqfb_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [2:0]           cfg_data,
    input  wire logic                 s_relative,
    input  wire logic [5:0]           s_col_or_led,
    input  wire logic [3:0]           s_row_or_ring,
    input  wire logic signed [7:0]    s_value,
    input  wire lqfb_pkg::dp_cmd_t    cmd,
    output lqfb_pkg::dp_status_t      status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_quad_index,
    output logic [3:0]                m_x_offset,
    output logic [3:0]                m_y_offset,
    output logic [63:0]               m_levels_a,
    output logic [63:0]               m_levels_b,
    output logic [63:0]               m_levels_c,
    output logic [63:0]               m_levels_d,
    output logic                      m_last_quad
);
    import lqfb_pkg::*;

    // Configuration
    logic       ring_mode_reg;
    logic [2:0] active_quads_reg;
    logic [1:0] rotation_reg;

    // Captured request
    logic              rel_reg;
    logic [5:0]        col_reg;
    logic [3:0]        row_reg;
    logic signed [7:0] value_reg;

    // Level store: one row per quad, row valid bits stand for the reset zeros
    logic [ROW_W-1:0]     levels_reg [MAX_QUADS];
    logic [MAX_QUADS-1:0] row_valid_reg;
    logic [MAX_QUADS-1:0] dirty_reg;

    // Result register
    logic              m_valid_reg;
    logic [QUAD_W-1:0] quad_index_reg;
    logic [3:0]        x_offset_reg;
    logic [3:0]        y_offset_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              last_quad_reg;

    logic [QUAD_W-1:0] addr_quad;
    logic [LED_W-1:0]  addr_led;
    logic [QUAD_W-1:0] sel_quad;
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  one_row;
    logic [ROW_W-1:0]  all_row;
    logic [3:0]        x_off;
    logic [3:0]        y_off;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_mode_reg    <= 1'b0;
            active_quads_reg <= ACTIVE_MAX;
            rotation_reg     <= '0;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_RING_MODE:    ring_mode_reg    <= cfg_data[0];
                REG_ACTIVE_QUADS: active_quads_reg <= cfg_data;
                REG_ROTATION:     rotation_reg     <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rel_reg   <= s_relative;
            col_reg   <= s_col_or_led;
            row_reg   <= s_row_or_ring;
            value_reg <= s_value;
        end
    end

    // Single LED address: ring number and LED, or grid quad and offset
    always_comb begin
        if (ring_mode_reg) begin
            addr_quad = row_reg[1:0];
            addr_led  = col_reg;
        end else begin
            addr_quad = {row_reg[3], (col_reg > 6'd7)};
            addr_led  = {row_reg[2:0], col_reg[2:0]};
        end
    end

    assign sel_quad = (cmd.op == DP_WRITE_ONE) ? addr_quad : cmd.quad;
    assign rd_row   = row_valid_reg[sel_quad] ? levels_reg[sel_quad] : '0;

    // Updated rows for a single write and for a whole-quad write
    always_comb begin
        one_row = rd_row;
        one_row[addr_led*LEVEL_W +: LEVEL_W] =
            sat_level(rd_row[addr_led*LEVEL_W +: LEVEL_W], value_reg, rel_reg);
        for (int k = 0; k < LEDS_PER_QUAD; k++) begin
            all_row[k*LEVEL_W +: LEVEL_W] =
                sat_level(rd_row[k*LEVEL_W +: LEVEL_W], value_reg, rel_reg);
        end
    end

    // Level rows
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_WRITE_ONE: levels_reg[sel_quad] <= one_row;
            DP_WRITE_ALL: levels_reg[sel_quad] <= all_row;
            default:      ;
        endcase
    end

    // Row valid bits and dirty marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            dirty_reg     <= '0;
        end else begin
            case (cmd.op)
                DP_WRITE_ONE, DP_WRITE_ALL: begin
                    row_valid_reg[sel_quad] <= 1'b1;
                    dirty_reg[sel_quad]     <= 1'b1;
                end
                DP_EMIT: begin
                    dirty_reg[sel_quad] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Grid offsets of the emitted quad
    always_comb begin
        x_off = BASE_XOFF[sel_quad];
        y_off = BASE_YOFF[sel_quad];
        if ((active_quads_reg == ACTIVE_PAIR) && (sel_quad == 2'd1) && rotation_reg[0]) begin
            x_off = 4'd0;
            y_off = 4'd8;
        end
        if (ring_mode_reg) begin
            x_off = 4'd0;
            y_off = 4'd0;
        end
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == DP_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_EMIT) begin
            quad_index_reg <= sel_quad;
            x_offset_reg   <= x_off;
            y_offset_reg   <= y_off;
            out_row_reg    <= rd_row;
            last_quad_reg  <= cmd.last;
        end
    end

    assign status.dirty        = dirty_reg;
    assign status.active_count = (active_quads_reg > ACTIVE_MAX) ? ACTIVE_MAX : active_quads_reg;
    assign status.out_free     = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_quad_index = quad_index_reg;
    assign m_x_offset   = x_offset_reg;
    assign m_y_offset   = y_offset_reg;
    assign m_levels_a   = out_row_reg[0*WORD_W +: WORD_W];
    assign m_levels_b   = out_row_reg[1*WORD_W +: WORD_W];
    assign m_levels_c   = out_row_reg[2*WORD_W +: WORD_W];
    assign m_levels_d   = out_row_reg[3*WORD_W +: WORD_W];
    assign m_last_quad  = last_quad_reg;

endmodule

`default_nettype wire
